// ----- design/lua_token_lexer_unit_macros.svh -----
// Assertion macros for the Lua token lexer checker.
// Included by the checker file only.
`ifndef LUA_TOKEN_LEXER_UNIT_MACROS_SVH
`define LUA_TOKEN_LEXER_UNIT_MACROS_SVH
`define LTL_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/ltl_pkg.sv -----
// Package for the Lua token lexer: widths, token kinds, scan modes and result type.
// No dependencies.
package ltl_pkg;
    localparam int KEYWORD_BYTES = 8;
    localparam int KW_IDX_BITS   = $clog2(KEYWORD_BYTES);
    localparam int OFFSET_BITS   = 32;
    localparam int LEN_BITS      = 16;
    localparam int LINE_BITS     = 24;
    localparam int MAX_RES       = 3;

    localparam logic [5:0] K_NAME   = 6'd21;
    localparam logic [5:0] K_NUMBER = 6'd22;
    localparam logic [5:0] K_STRING = 6'd23;
    localparam logic [5:0] K_EOS    = 6'd50;
    localparam logic [5:0] K_NONE   = 6'd63;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_BLOCK  = 3'd1;
    localparam logic [2:0] E_STRING = 3'd2;
    localparam logic [2:0] E_TILDE  = 3'd3;
    localparam logic [2:0] E_BADCH  = 3'd4;

    typedef enum logic [4:0] {
        M_IDLE, M_OPP, M_CMT_START, M_CMT_BRACKET, M_LINE, M_BLOCK, M_BLOCK_CLOSE,
        M_NAME, M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXP, M_NUM_HEX,
        M_STRING, M_STRING_ESC, M_STOP
    } t_mode;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic                   is_payload;
        logic [7:0]             payload_byte;
        logic [2:0]             error_code;
        logic [LINE_BITS-1:0]   line_number;
        logic [31:0]            start_offset;
        logic [LEN_BITS-1:0]    text_length;
        logic                   last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_bundle;

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            "+": single_kind = 6'd24;
            "-": single_kind = 6'd25;
            "*": single_kind = 6'd26;
            "/": single_kind = 6'd27;
            "%": single_kind = 6'd29;
            "^": single_kind = 6'd30;
            "#": single_kind = 6'd31;
            "(": single_kind = 6'd32;
            ")": single_kind = 6'd33;
            "{": single_kind = 6'd34;
            "}": single_kind = 6'd35;
            "[": single_kind = 6'd36;
            "]": single_kind = 6'd37;
            ";": single_kind = 6'd38;
            ":": single_kind = 6'd39;
            ",": single_kind = 6'd40;
            "=": single_kind = 6'd41;
            "<": single_kind = 6'd44;
            ">": single_kind = 6'd46;
            ".": single_kind = 6'd48;
            default: single_kind = K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
        pair_kind = K_NONE;
        if (p == "/" && b == "/") pair_kind = 6'd28;
        if (p == "=" && b == "=") pair_kind = 6'd42;
        if (p == "~" && b == "=") pair_kind = 6'd43;
        if (p == "<" && b == "=") pair_kind = 6'd45;
        if (p == ">" && b == "=") pair_kind = 6'd47;
        if (p == "." && b == ".") pair_kind = 6'd49;
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [63:0] w);
        case (w)
            {"and", 40'd0}:      keyword_kind = 6'd0;
            {"break", 24'd0}:    keyword_kind = 6'd1;
            {"do", 48'd0}:       keyword_kind = 6'd2;
            {"else", 32'd0}:     keyword_kind = 6'd3;
            {"elseif", 16'd0}:   keyword_kind = 6'd4;
            {"end", 40'd0}:      keyword_kind = 6'd5;
            {"false", 24'd0}:    keyword_kind = 6'd6;
            {"for", 40'd0}:      keyword_kind = 6'd7;
            "function":          keyword_kind = 6'd8;
            {"if", 48'd0}:       keyword_kind = 6'd9;
            {"in", 48'd0}:       keyword_kind = 6'd10;
            {"local", 24'd0}:    keyword_kind = 6'd11;
            {"nil", 40'd0}:      keyword_kind = 6'd12;
            {"not", 40'd0}:      keyword_kind = 6'd13;
            {"or", 48'd0}:       keyword_kind = 6'd14;
            {"repeat", 16'd0}:   keyword_kind = 6'd15;
            {"return", 16'd0}:   keyword_kind = 6'd16;
            {"then", 32'd0}:     keyword_kind = 6'd17;
            {"true", 32'd0}:     keyword_kind = 6'd18;
            {"until", 24'd0}:    keyword_kind = 6'd19;
            {"while", 24'd0}:    keyword_kind = 6'd20;
            default:             keyword_kind = K_NAME;
        endcase
    endfunction
endpackage

// ----- design/ltl_if.sv -----
// Valid/ready stream interfaces for the Lua token lexer.
// Depends on ltl_pkg.
interface ltl_in_if import ltl_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;
    modport source (output valid, source_byte, end_of_input, input ready);
    modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

interface ltl_out_if import ltl_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- design/ltl_scanner.sv -----
// Scanner state and per-byte next-state logic; produces up to two results per request.
// Depends on ltl_pkg.
module ltl_scanner import ltl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_bundle    o_bundle
);
    t_mode                 r_mode, n_mode;
    logic [7:0]            r_pend, n_pend;
    logic [7:0]            r_kw [KEYWORD_BYTES];
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [OFFSET_BITS-1:0] r_off;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [LINE_BITS-1:0]  r_tline, n_tline;
    logic [LEN_BITS-1:0]   r_tlen, n_tlen;
    logic                  r_quote, n_quote;
    logic                  kw_we0, kw_wen;
    logic [LEN_BITS-1:0]   grown;
    logic [63:0]           kw_word;
    t_result               res [2];
    logic [1:0]            cnt;

    assign grown = (r_tlen == {LEN_BITS{1'b1}}) ? r_tlen : r_tlen + 1'b1;

    always_comb begin
        kw_word = '0;
        for (int i = 0; i < 8; i++) begin
            if (LEN_BITS'(i) < r_tlen) kw_word[63-8*i -: 8] = r_kw[i];
        end
    end

    function automatic logic is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_alp(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic is_hex(input logic [7:0] b);
        return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic t_result mk(input logic [5:0] k, input logic p, input logic [7:0] pb,
        input logic [2:0] e, input logic [LINE_BITS-1:0] l,
        input logic [OFFSET_BITS-1:0] s, input logic [LEN_BITS-1:0] n);
        t_result r;
        r.token_kind = k; r.is_payload = p; r.payload_byte = pb; r.error_code = e;
        r.line_number = l; r.start_offset = 32'(s); r.text_length = n; r.last_of_run = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic do_idle, do_flush;
        t_result fl;
        n_mode = r_mode; n_pend = r_pend; n_tstart = r_tstart; n_tline = r_tline;
        n_tlen = r_tlen; n_quote = r_quote; kw_we0 = 1'b0; kw_wen = 1'b0;
        res[0] = '0; res[1] = '0; cnt = 2'd0;
        do_idle = 1'b0; do_flush = 1'b0;
        n_line = r_line;
        if (r_mode == M_NAME) fl = mk((r_tlen > LEN_BITS'(8)) ? K_NAME : keyword_kind(kw_word),
            1'b0, 8'd0, E_NONE, r_tline, r_tstart, r_tlen);
        else if (r_mode == M_OPP) fl = mk(single_kind(r_pend), 1'b0, 8'd0, E_NONE, r_tline,
            r_tstart, LEN_BITS'(1));
        else fl = mk(K_NUMBER, 1'b0, 8'd0, E_NONE, r_tline, r_tstart, r_tlen);
        if (i_end || i_byte == 8'd0) begin
            case (r_mode)
                M_STOP: ;
                M_BLOCK, M_BLOCK_CLOSE: begin
                    res[0] = mk(K_EOS, 1'b0, 8'd0, E_BLOCK, r_line, r_off, '0); cnt = 2'd1;
                end
                M_STRING, M_STRING_ESC: begin
                    res[0] = mk(K_EOS, 1'b0, 8'd0, E_STRING, r_tline, r_off, '0); cnt = 2'd1;
                end
                M_IDLE, M_CMT_START, M_CMT_BRACKET, M_LINE: begin
                    res[0] = mk(K_EOS, 1'b0, 8'd0, E_NONE, r_line, r_off, '0); cnt = 2'd1;
                end
                default: begin
                    if (r_mode == M_OPP && r_pend == "~") begin
                        res[0] = mk(K_EOS, 1'b0, 8'd0, E_TILDE, r_tline, r_off, '0);
                        cnt = 2'd1;
                    end else begin
                        res[0] = fl;
                        res[1] = mk(K_EOS, 1'b0, 8'd0, E_NONE, r_line, r_off, '0);
                        cnt = 2'd2;
                    end
                end
            endcase
            n_mode = M_STOP;
        end else if (r_mode != M_STOP) begin
            case (r_mode)
                M_IDLE: do_idle = 1'b1;
                M_OPP: begin
                    if (r_pend == "-" && i_byte == "-") n_mode = M_CMT_START;
                    else if (r_pend == "." && is_dig(i_byte)) begin
                        n_tlen = grown; n_mode = M_NUM_FRAC;
                    end else if (pair_kind(r_pend, i_byte) != K_NONE) begin
                        res[0] = mk(pair_kind(r_pend, i_byte), 1'b0, 8'd0, E_NONE, r_tline,
                            r_tstart, LEN_BITS'(2));
                        cnt = 2'd1; n_mode = M_IDLE;
                    end else if (r_pend == "~") begin
                        res[0] = mk(K_EOS, 1'b0, 8'd0, E_TILDE, r_tline, r_off, '0);
                        cnt = 2'd1; n_mode = M_STOP;
                    end else do_flush = 1'b1;
                end
                M_CMT_START, M_CMT_BRACKET: begin
                    if (i_byte == "[") n_mode = (r_mode == M_CMT_START) ? M_CMT_BRACKET : M_BLOCK;
                    else n_mode = (i_byte == 8'h0a) ? M_IDLE : M_LINE;
                end
                M_LINE: if (i_byte == 8'h0a) n_mode = M_IDLE;
                M_BLOCK: if (i_byte == "]") n_mode = M_BLOCK_CLOSE;
                M_BLOCK_CLOSE: n_mode = (i_byte == "]") ? M_IDLE : M_BLOCK;
                M_NAME: begin
                    if (is_alp(i_byte) || is_dig(i_byte) || i_byte == "_") begin
                        kw_wen = r_tlen < LEN_BITS'(KEYWORD_BYTES);
                        n_tlen = grown;
                    end else do_flush = 1'b1;
                end
                M_STRING: begin
                    if (i_byte == (r_quote ? 8'h27 : 8'h22)) begin
                        res[0] = mk(K_STRING, 1'b0, 8'd0, E_NONE, r_tline, r_tstart, grown);
                        cnt = 2'd1; n_mode = M_IDLE; n_tlen = grown;
                    end else if (i_byte == 8'h0a) begin
                        res[0] = mk(K_EOS, 1'b0, 8'd0, E_STRING, r_tline, r_off, '0);
                        cnt = 2'd1; n_mode = M_STOP;
                    end else begin
                        n_tlen = grown;
                        if (i_byte == 8'h5c) n_mode = M_STRING_ESC;
                        else begin
                            res[0] = mk(K_STRING, 1'b1, i_byte, E_NONE, r_tline, r_tstart, '0);
                            cnt = 2'd1;
                        end
                    end
                end
                M_STRING_ESC: begin
                    n_tlen = grown; n_mode = M_STRING; cnt = 2'd1;
                    res[0] = mk(K_STRING, 1'b1, (i_byte == "n") ? 8'd10 : (i_byte == "t") ? 8'd9 :
                        (i_byte == "r") ? 8'd13 : (i_byte == "0") ? 8'd0 : i_byte,
                        E_NONE, r_tline, r_tstart, '0);
                end
                M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXP, M_NUM_HEX: begin
                    if (r_mode == M_NUM_ZERO && (i_byte == "x" || i_byte == "X")) begin
                        n_tlen = grown; n_mode = M_NUM_HEX;
                    end else if (r_mode == M_NUM_HEX) begin
                        if (is_hex(i_byte)) n_tlen = grown; else do_flush = 1'b1;
                    end else if (r_mode == M_NUM_EXPS) begin
                        if (i_byte == "+" || i_byte == "-" || is_dig(i_byte)) begin
                            n_tlen = grown; n_mode = M_NUM_EXP;
                        end else do_flush = 1'b1;
                    end else if (is_dig(i_byte)) begin
                        n_tlen = grown; n_mode = (r_mode == M_NUM_ZERO) ? M_NUM_INT : r_mode;
                    end else if ((r_mode == M_NUM_INT || r_mode == M_NUM_ZERO)
                        && i_byte == ".") begin
                        n_tlen = grown; n_mode = M_NUM_FRAC;
                    end else if (r_mode != M_NUM_EXP && (i_byte == "e" || i_byte == "E")) begin
                        n_tlen = grown; n_mode = M_NUM_EXPS;
                    end else do_flush = 1'b1;
                end
                default: ;
            endcase
            if (do_flush) begin
                res[0] = fl; cnt = 2'd1; n_mode = M_IDLE; do_idle = 1'b1;
            end
            if (do_idle) begin
                n_mode = M_IDLE;
                if (i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0d || i_byte == 8'h0a) ;
                else if (is_dig(i_byte) || is_alp(i_byte) || i_byte == "_" ||
                    i_byte == 8'h22 || i_byte == 8'h27 || i_byte == "-" || i_byte == "/" ||
                    i_byte == "=" || i_byte == "~" || i_byte == "<" || i_byte == ">" ||
                    i_byte == ".") begin
                    n_tstart = r_off; n_tline = r_line; n_tlen = LEN_BITS'(1);
                    if (is_dig(i_byte)) n_mode = (i_byte == "0") ? M_NUM_ZERO : M_NUM_INT;
                    else if (is_alp(i_byte) || i_byte == "_") begin
                        n_mode = M_NAME; kw_we0 = 1'b1;
                    end else if (i_byte == 8'h22 || i_byte == 8'h27) begin
                        n_mode = M_STRING; n_quote = (i_byte == 8'h27);
                    end else begin
                        n_mode = M_OPP; n_pend = i_byte;
                    end
                end else if (single_kind(i_byte) != K_NONE) begin
                    res[cnt[0]] = mk(single_kind(i_byte), 1'b0, 8'd0, E_NONE, r_line, r_off,
                        LEN_BITS'(1));
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt[0]] = mk(K_EOS, 1'b0, 8'd0, E_BADCH, r_line, r_off, '0);
                    cnt = cnt + 2'd1; n_mode = M_STOP;
                end
            end
            if (i_byte == 8'h0a && r_line != {LINE_BITS{1'b1}}) n_line = r_line + 1'b1;
        end
    end

    always_comb begin
        o_bundle.count = cnt;
        o_bundle.r0 = res[0];
        o_bundle.r1 = res[1];
        if (cnt == 2'd1) o_bundle.r0.last_of_run = 1'b1;
        if (cnt == 2'd2) o_bundle.r1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pend <= '0; r_line <= LINE_BITS'(1); r_off <= '0;
            r_tstart <= '0; r_tline <= LINE_BITS'(1); r_tlen <= '0; r_quote <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode; r_pend <= n_pend; r_line <= n_line; r_tstart <= n_tstart;
            r_tline <= n_tline; r_tlen <= n_tlen; r_quote <= n_quote;
            if (!(i_end || i_byte == 8'd0) && r_mode != M_STOP) r_off <= r_off + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && kw_we0) r_kw[0] <= i_byte;
        if (i_take && kw_wen) r_kw[r_tlen[KW_IDX_BITS-1:0]] <= i_byte;
    end
endmodule

// ----- design/ltl_out_queue.sv -----
// Four-entry result buffer; drains one result per cycle while the receiver is ready.
// Depends on ltl_pkg.
module ltl_out_queue import ltl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_space,
    ltl_out_if.source o_out
);
    t_result    r_q [4];
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;
    logic [1:0] npush;

    assign pop     = o_out.valid && o_out.ready;
    assign npush   = i_push ? i_bundle.count : 2'd0;
    assign o_space = r_cnt <= 3'd2;
    assign o_out.valid = r_cnt != 3'd0;
    assign o_out.data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        logic [1:0] wr;
        wr = r_rd + r_cnt[1:0];
        if (npush != 2'd0) r_q[wr] <= i_bundle.r0;
        if (npush == 2'd2) r_q[wr + 2'd1] <= i_bundle.r1;
        if (!i_rst_n) begin
            r_rd <= '0; r_cnt <= '0;
        end else begin
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, npush} - {2'b0, pop};
        end
    end
endmodule

// ----- design/lua_token_lexer_unit.sv -----
// Top level of the Lua token lexer: scanner and result buffer.
// Depends on ltl_pkg, ltl_if, ltl_scanner and ltl_out_queue.
// One source byte is taken per cycle; each byte yields zero to two result requests, which
// pass through a four-entry buffer that drains one per cycle while the output is ready,
// so input stalls only while the buffer holds more than two waiting results.
module lua_token_lexer_unit import ltl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ltl_in_if.sink    i_in,
    ltl_out_if.source o_out
);
    logic    space, take;
    t_bundle bundle;

    assign i_in.ready = space;
    assign take = i_in.valid && space;

    ltl_scanner u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_byte(i_in.source_byte),
        .i_end(i_in.end_of_input), .o_bundle(bundle)
    );

    ltl_out_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(take), .i_bundle(bundle),
        .o_space(space), .o_out(o_out)
    );
endmodule

// ----- design/ltl_checker.sv -----
// Port-level assertions for the Lua token lexer and the bind that attaches them.
// Depends on ltl_pkg and the macro header.
`include "lua_token_lexer_unit_macros.svh"
module ltl_checker import ltl_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out_data
);
    logic pay_ok, err_ok;

    assign pay_ok = !(i_out_valid && i_out_data.is_payload) || i_out_data.token_kind == K_STRING;
    assign err_ok = !(i_out_valid && i_out_data.error_code != E_NONE)
                    || (i_out_data.token_kind == K_EOS && i_out_data.last_of_run);

    `LTL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")
    `LTL_ASSERT_IMPL(a_payload_kind, i_clk, i_rst_n, pay_ok, "payload not string")
    `LTL_ASSERT_IMPL(a_err_eos, i_clk, i_rst_n, err_ok, "error item malformed")
    `LTL_ASSERT_IMPL(a_line, i_clk, i_rst_n, !i_out_valid || i_out_data.line_number != '0, "line zero")
    `LTL_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, i_out_valid || i_in_ready, "empty but not ready")
endmodule

bind lua_token_lexer_unit ltl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready), .i_out_data(o_out.data)
);

// ----- sim/lua_token_lexer_unit_test.sv -----
// Self-checking testbench for lua_token_lexer_unit: random Lua-like source text in,
// token results checked in order against a scanner predictor kept in this file.
// Depends on ltl_pkg, ltl_in_if, ltl_out_if and lua_token_lexer_unit from the design folder.
module lua_token_lexer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ltl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [5:0] T_PLUS = 6'd24, T_MINUS = 6'd25, T_STAR = 6'd26, T_SLASH = 6'd27;
    localparam logic [5:0] T_DSLASH = 6'd28, T_PCT = 6'd29, T_CARET = 6'd30, T_HASH = 6'd31;
    localparam logic [5:0] T_LPAR = 6'd32, T_RPAR = 6'd33, T_LBRACE = 6'd34;
    localparam logic [5:0] T_RBRACE = 6'd35, T_LBRACK = 6'd36, T_RBRACK = 6'd37;
    localparam logic [5:0] T_SEMI = 6'd38, T_COLON = 6'd39, T_COMMA = 6'd40;
    localparam logic [5:0] T_ASSIGN = 6'd41, T_EQ = 6'd42, T_NE = 6'd43, T_LT = 6'd44;
    localparam logic [5:0] T_LE = 6'd45, T_GT = 6'd46, T_GE = 6'd47, T_DOT = 6'd48;
    localparam logic [5:0] T_CONCAT = 6'd49;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } t_src;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ltl_in_if  in_if();
    ltl_out_if o_if();

    lua_token_lexer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (o_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    string kw_names[21] = '{"and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "if", "in", "local", "nil", "not", "or", "repeat", "return", "then",
        "true", "until", "while"};
    string op_texts[26] = '{"+", "-", "*", "/", "//", "%", "^", "#", "(", ")", "{", "}",
        "[", "]", ";", ":", ",", "=", "==", "~=", "<", "<=", ">", ">=", ".", ".."};

    t_src    src_q[$];
    t_result token_q[$];
    int      total_bytes;
    int      accepted_bytes = 0;
    int      errors = 0;
    int      cycles = 0;
    int      hold_cnt = 0;
    bit      hold_done = 1'b0;
    bit      src_go = 1'b0;
    bit      in_fire = 1'b0;
    int      phase = 0;
    t_src    drv_item;

    // Scanner state mirrored from the block.
    t_mode       lx_mode = M_IDLE;
    logic [7:0]  lx_pend = '0;
    logic [7:0]  lx_word[KEYWORD_BYTES];
    logic [23:0] lx_line = 24'd1;
    logic [23:0] lx_tok_line = 24'd1;
    logic [31:0] lx_off = '0;
    logic [31:0] lx_tok_start = '0;
    logic [15:0] lx_len = '0;
    logic        lx_squote = 1'b0;
    int          step_n;

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_hex(logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [5:0] op1_kind(logic [7:0] b);
        case (b)
            "+": return T_PLUS;    "-": return T_MINUS;  "*": return T_STAR;
            "/": return T_SLASH;   "%": return T_PCT;    "^": return T_CARET;
            "#": return T_HASH;    "(": return T_LPAR;   ")": return T_RPAR;
            "{": return T_LBRACE;  "}": return T_RBRACE; "[": return T_LBRACK;
            "]": return T_RBRACK;  ";": return T_SEMI;   ":": return T_COLON;
            ",": return T_COMMA;   "=": return T_ASSIGN; "<": return T_LT;
            ">": return T_GT;      ".": return T_DOT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] op2_kind(logic [7:0] p, logic [7:0] b);
        if (p == "/" && b == "/") return T_DSLASH;
        if (p == "=" && b == "=") return T_EQ;
        if (p == "~" && b == "=") return T_NE;
        if (p == "<" && b == "=") return T_LE;
        if (p == ">" && b == "=") return T_GE;
        if (p == "." && b == ".") return T_CONCAT;
        return K_NONE;
    endfunction

    function logic [5:0] word_kind();
        bit same;
        if (lx_len > 8) return K_NAME;
        for (int k = 0; k < 21; k++) begin
            if (kw_names[k].len() == lx_len) begin
                same = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++)
                    if (kw_names[k][i] != lx_word[i]) same = 1'b0;
                if (same) return 6'(k);
            end
        end
        return K_NAME;
    endfunction

    function void add_token(logic [5:0] kind, logic pay, logic [7:0] pb, logic [2:0] err,
                            logic [23:0] line, logic [31:0] start, logic [15:0] len);
        t_result r;
        if (step_n >= MAX_RES) return;
        r.token_kind   = kind;
        r.is_payload   = pay;
        r.payload_byte = pb;
        r.error_code   = err;
        r.line_number  = line;
        r.start_offset = start;
        r.text_length  = len;
        r.last_of_run  = 1'b0;
        token_q.insert(token_q.size(), r);
        step_n++;
    endfunction

    function void grow();
        if (lx_len != 16'hFFFF) lx_len++;
    endfunction

    function void stop_with(logic [2:0] code, logic [23:0] line);
        add_token(K_EOS, 1'b0, 8'd0, code, line, lx_off, 16'd0);
        lx_mode = M_STOP;
    endfunction

    function void flush_pending();
        if (lx_mode == M_NAME)
            add_token(word_kind(), 1'b0, 8'd0, E_NONE, lx_tok_line, lx_tok_start, lx_len);
        else if (lx_mode == M_OPP)
            add_token(op1_kind(lx_pend), 1'b0, 8'd0, E_NONE, lx_tok_line, lx_tok_start, 16'd1);
        else
            add_token(K_NUMBER, 1'b0, 8'd0, E_NONE, lx_tok_line, lx_tok_start, lx_len);
        lx_mode = M_IDLE;
    endfunction

    function void open_token(t_mode m);
        lx_tok_start = lx_off;
        lx_tok_line  = lx_line;
        lx_len       = 16'd1;
        lx_mode      = m;
    endfunction

    function void scan_idle(logic [7:0] b);
        if (b == " " || b == "\t" || b == "\r" || b == "\n") return;
        if (is_digit(b)) begin
            open_token(b == "0" ? M_NUM_ZERO : M_NUM_INT);
        end else if (is_alpha(b) || b == "_") begin
            open_token(M_NAME);
            lx_word[0] = b;
        end else if (b == "\"" || b == "'") begin
            open_token(M_STRING);
            lx_squote = (b == "'");
        end else if (b == "-" || b == "/" || b == "=" || b == "~" || b == "<" || b == ">"
                     || b == ".") begin
            open_token(M_OPP);
            lx_pend = b;
        end else if (op1_kind(b) != K_NONE) begin
            add_token(op1_kind(b), 1'b0, 8'd0, E_NONE, lx_line, lx_off, 16'd1);
        end else begin
            stop_with(E_BADCH, lx_line);
        end
    endfunction

    function void scan_number(logic [7:0] b);
        t_mode m;
        m = lx_mode;
        if (m == M_NUM_ZERO) begin
            if (b == "x" || b == "X") begin
                grow();
                lx_mode = M_NUM_HEX;
                return;
            end
            m = M_NUM_INT;
            lx_mode = M_NUM_INT;
        end
        if (m == M_NUM_HEX) begin
            if (is_hex(b)) begin
                grow();
                return;
            end
        end else if (m == M_NUM_EXPS) begin
            if (b == "+" || b == "-" || is_digit(b)) begin
                grow();
                lx_mode = M_NUM_EXP;
                return;
            end
        end else if (is_digit(b)) begin
            grow();
            return;
        end else if (m == M_NUM_INT && b == ".") begin
            grow();
            lx_mode = M_NUM_FRAC;
            return;
        end else if ((m == M_NUM_INT || m == M_NUM_FRAC) && (b == "e" || b == "E")) begin
            grow();
            lx_mode = M_NUM_EXPS;
            return;
        end
        flush_pending();
        scan_idle(b);
    endfunction

    function void scan_byte(logic [7:0] b);
        logic [5:0] k;
        logic [7:0] v;
        case (lx_mode)
            M_STOP: ;
            M_IDLE: scan_idle(b);
            M_OPP: begin
                k = op2_kind(lx_pend, b);
                if (lx_pend == "-" && b == "-") begin
                    lx_mode = M_CMT_START;
                end else if (lx_pend == "." && is_digit(b)) begin
                    grow();
                    lx_mode = M_NUM_FRAC;
                end else if (k != K_NONE) begin
                    add_token(k, 1'b0, 8'd0, E_NONE, lx_tok_line, lx_tok_start, 16'd2);
                    lx_mode = M_IDLE;
                end else if (lx_pend == "~") begin
                    stop_with(E_TILDE, lx_tok_line);
                end else begin
                    flush_pending();
                    scan_idle(b);
                end
            end
            M_CMT_START, M_CMT_BRACKET: begin
                if (b == "[") lx_mode = (lx_mode == M_CMT_START) ? M_CMT_BRACKET : M_BLOCK;
                else lx_mode = (b == "\n") ? M_IDLE : M_LINE;
            end
            M_LINE: if (b == "\n") lx_mode = M_IDLE;
            M_BLOCK: if (b == "]") lx_mode = M_BLOCK_CLOSE;
            M_BLOCK_CLOSE: lx_mode = (b == "]") ? M_IDLE : M_BLOCK;
            M_NAME: begin
                if (is_alpha(b) || is_digit(b) || b == "_") begin
                    if (lx_len < KEYWORD_BYTES) lx_word[lx_len] = b;
                    grow();
                end else begin
                    flush_pending();
                    scan_idle(b);
                end
            end
            M_STRING: begin
                if (b == (lx_squote ? "'" : "\"")) begin
                    grow();
                    add_token(K_STRING, 1'b0, 8'd0, E_NONE, lx_tok_line, lx_tok_start, lx_len);
                    lx_mode = M_IDLE;
                end else if (b == "\n") begin
                    stop_with(E_STRING, lx_tok_line);
                end else begin
                    grow();
                    if (b == "\\") lx_mode = M_STRING_ESC;
                    else add_token(K_STRING, 1'b1, b, E_NONE, lx_tok_line, lx_tok_start, 16'd0);
                end
            end
            M_STRING_ESC: begin
                grow();
                v = (b == "n") ? 8'd10 : (b == "t") ? 8'd9 : (b == "r") ? 8'd13 :
                    (b == "0") ? 8'd0 : b;
                add_token(K_STRING, 1'b1, v, E_NONE, lx_tok_line, lx_tok_start, 16'd0);
                lx_mode = M_STRING;
            end
            default: scan_number(b);
        endcase
    endfunction

    function void scan_end();
        case (lx_mode)
            M_STOP: return;
            M_BLOCK, M_BLOCK_CLOSE: begin
                stop_with(E_BLOCK, lx_line);
                return;
            end
            M_STRING, M_STRING_ESC: begin
                stop_with(E_STRING, lx_tok_line);
                return;
            end
            M_OPP: begin
                if (lx_pend == "~") begin
                    stop_with(E_TILDE, lx_tok_line);
                    return;
                end
                flush_pending();
            end
            M_IDLE, M_CMT_START, M_CMT_BRACKET, M_LINE: ;
            default: flush_pending();
        endcase
        add_token(K_EOS, 1'b0, 8'd0, E_NONE, lx_line, lx_off, 16'd0);
        lx_mode = M_STOP;
    endfunction

    function void predict_tokens(logic [7:0] b, logic eoi);
        step_n = 0;
        if (eoi || b == 8'd0) begin
            scan_end();
        end else if (lx_mode != M_STOP) begin
            scan_byte(b);
            if (b == "\n" && lx_line != 24'hFFFFFF) lx_line++;
            lx_off++;
        end
        if (step_n > 0) token_q[$].last_of_run = 1'b1;
    endfunction

    // Stimulus construction.
    function void put_byte(logic [7:0] b, logic eoi = 1'b0);
        t_src s;
        s.b   = b;
        s.eoi = eoi;
        src_q.insert(src_q.size(), s);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function void put_digits(int lo, int hi);
        repeat ($urandom_range(lo, hi)) put_byte(8'("0" + $urandom_range(0, 9)));
    endfunction

    function void put_string();
        logic [7:0] q, c;
        string esc = "ntr0q\\\"'\n";
        q = $urandom_range(0, 1) ? "'" : "\"";
        put_byte(q);
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 3) == 0) begin
                put_byte("\\");
                if ($urandom_range(0, 1)) put_byte(esc[$urandom_range(0, esc.len() - 1)]);
                else put_byte(8'($urandom_range(1, 255)));
            end else begin
                do c = 8'($urandom_range(1, 255)); while (c == q || c == "\\" || c == "\n");
                put_byte(c);
            end
        end
        put_byte(q);
    endfunction

    function void put_comment(bit block);
        logic [7:0] c;
        put_text(block ? "--[[" : "--");
        repeat ($urandom_range(0, 10)) begin
            do c = 8'($urandom_range(1, 255));
            while (block ? c == "]" : (c == "\n" || c == "["));
            put_byte(c);
        end
        if (block && $urandom_range(0, 1)) put_text("]x");
        put_text(block ? "]]" : "\n");
    endfunction

    function void put_token();
        int r, k;
        string noise = "abz09_+*;,.<>=/";
        string blanks = " \t\r\n";
        string hex_digits = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        k = 0;
        if (r < 22) begin
            put_text(kw_names[$urandom_range(0, 20)]);
        end else if (r < 38) begin
            put_byte(word_char(1'b1));
            repeat ($urandom_range(0, 11)) put_byte(word_char(1'b0));
        end else if (r < 53) begin
            case ($urandom_range(0, 4))
                0: put_digits(1, 4);
                1: begin
                    put_text($urandom_range(0, 1) ? "0x" : "0X");
                    repeat ($urandom_range(1, 4)) put_byte(hex_digits[$urandom_range(0, 21)]);
                end
                2: begin put_digits(1, 3); put_byte("."); put_digits(0, 3); end
                3: begin
                    put_digits(1, 3);
                    put_byte($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1)) put_byte($urandom_range(0, 1) ? "+" : "-");
                    put_digits(1, 2);
                end
                default: begin put_byte("."); put_digits(1, 3); end
            endcase
        end else if (r < 68) begin
            put_string();
        end else if (r < 88) begin
            k = $urandom_range(0, 25);
            put_text(op_texts[k]);
        end else if (r < 93) begin
            put_comment(1'b0);
        end else if (r < 96) begin
            put_comment(1'b1);
        end else begin
            put_byte(noise[$urandom_range(0, noise.len() - 1)]);
        end
        // A minus sign is always followed by a blank so that no comment opens by accident.
        if (op_texts[k] == "-" && r >= 68 && r < 88 || $urandom_range(0, 99) < 85)
            repeat ($urandom_range(1, 2)) put_byte(blanks[$urandom_range(0, 3)]);
    endfunction

    function void build_source();
        put_text("x=0x1F..'a\\n\200'--[[]]]\n");
        while (src_q.size() < 440) put_token();
        put_byte(" ");
        case ($urandom_range(0, 5))
            0: put_byte(8'($urandom_range(0, 255)), 1'b1);
            1: put_byte(8'd0);
            2: begin put_text("--[[ab"); put_byte(8'd0, 1'b1); end
            3: begin put_text("\"ab"); put_byte($urandom_range(0, 1) ? "\n" : 8'd0); end
            4: put_text("~ ");
            default: put_byte(8'($urandom_range(128, 255)));
        endcase
        repeat (3) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
    endtask

    function int sender_idle_pct();
        return (phase == 0) ? 33 : (phase == 1) ? 57 : 0;
    endfunction

    function int receiver_idle_pct();
        return (phase == 0) ? 57 : (phase == 1) ? 33 : 0;
    endfunction

    // Request driver: a new request goes out once the previous one was taken.
    always @(negedge i_clk) begin
        if (!in_if.valid || in_fire) begin
            if (src_go && src_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                drv_item = src_q.pop_front();
                in_if.valid        <= 1'b1;
                in_if.source_byte  <= drv_item.b;
                in_if.end_of_input <= drv_item.eoi;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!src_go || hold_cnt > 0) o_if.ready <= 1'b0;
        else o_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    always @(posedge i_clk) begin
        if (phase == 2 && !hold_done) begin
            hold_cnt  = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        in_fire = in_if.valid && in_if.ready;
        if (in_fire) begin
            predict_tokens(in_if.source_byte, in_if.end_of_input);
            accepted_bytes++;
            phase = (accepted_bytes < total_bytes / 3) ? 0 :
                    (accepted_bytes < 2 * total_bytes / 3) ? 1 : 2;
        end
        if (o_if.valid && o_if.ready) begin
            got = o_if.data;
            if (token_q.size() == 0) begin
                report("unexpected token", 32'(got.token_kind), 32'(K_NONE));
            end else begin
                want = token_q.pop_front();
                if (got.token_kind !== want.token_kind)
                    report("token_kind", 32'(got.token_kind), 32'(want.token_kind));
                if (got.is_payload !== want.is_payload)
                    report("is_payload", 32'(got.is_payload), 32'(want.is_payload));
                if (got.payload_byte !== want.payload_byte)
                    report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
                if (got.error_code !== want.error_code)
                    report("error_code", 32'(got.error_code), 32'(want.error_code));
                if (got.line_number !== want.line_number)
                    report("line_number", 32'(got.line_number), 32'(want.line_number));
                if (got.start_offset !== want.start_offset)
                    report("start_offset", got.start_offset, want.start_offset);
                if (got.text_length !== want.text_length)
                    report("text_length", 32'(got.text_length), 32'(want.text_length));
                if (got.last_of_run !== want.last_of_run)
                    report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lua_token_lexer_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.source_byte  = 8'd0;
        in_if.end_of_input = 1'b0;
        o_if.ready         = 1'b0;
        build_source();
        total_bytes = src_q.size();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        src_go  = 1'b1;
        while (accepted_bytes < total_bytes) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("lua_token_lexer_unit_test: PASS");
        end else begin
            $display("lua_token_lexer_unit_test: FAIL");
        end
        $finish;
    end
endmodule
